// ----- rtl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned MAX_HEX_DIGITS = 8;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_ADDR_W     = 1;
  localparam int unsigned COUNT_W        = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_CHUNKED_MODE    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED_LENGTH = 1'b1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [1:0] PHASE_CODE_SIZE  = 2'd0;
  localparam logic [1:0] PHASE_CODE_DATA  = 2'd1;
  localparam logic [1:0] PHASE_CODE_TRAIL = 2'd2;
  localparam logic [1:0] PHASE_CODE_DONE  = 2'd3;

  localparam logic [1:0] TRAIL_SKIP_BYTES = 2'd2;

  typedef enum logic [3:0] {
    PH_SIZE  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_TRAIL = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] nibble;
    logic       is_hex;
    logic       is_cr;
    logic       is_lf;
  } item_t;

  function automatic logic [1:0] phase_code(input phase_e ph);
    logic [1:0] code;
    case (ph)
      PH_SIZE:  code = PHASE_CODE_SIZE;
      PH_DATA:  code = PHASE_CODE_DATA;
      PH_TRAIL: code = PHASE_CODE_TRAIL;
      PH_DONE:  code = PHASE_CODE_DONE;
      default:  code = PHASE_CODE_SIZE;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/hcbd_front.sv -----
// ----------------------------------------------------------------------------
// hcbd_front
// Input side: takes body bytes and tags hex digit, CR and LF.
// ----------------------------------------------------------------------------
module hcbd_front (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  output logic           push_o,
  output hcbd_pkg::item_t item_o,
  input  logic           q_ready_i
);

  logic [3:0] nibble;
  logic       is_hex;

  always_comb begin
    nibble = 4'd0;
    is_hex = 1'b0;
    if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      nibble = data_byte_i[3:0];
      is_hex = 1'b1;
    end else if ((data_byte_i >= 8'h61 && data_byte_i <= 8'h66) ||
                 (data_byte_i >= 8'h41 && data_byte_i <= 8'h46)) begin
      nibble = data_byte_i[3:0] + 4'd9;
      is_hex = 1'b1;
    end
  end

  assign item_o.data   = data_byte_i;
  assign item_o.nibble = nibble;
  assign item_o.is_hex = is_hex;
  assign item_o.is_cr  = (data_byte_i == hcbd_pkg::CHAR_CR);
  assign item_o.is_lf  = (data_byte_i == hcbd_pkg::CHAR_LF);

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i;

endmodule

// ----- rtl/hcbd_queue.sv -----
// ----------------------------------------------------------------------------
// hcbd_queue
// Short queue of tagged beats between the front and back sides.
// ----------------------------------------------------------------------------
module hcbd_queue #(
  parameter int unsigned Depth = hcbd_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hcbd_pkg::item_t item_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output hcbd_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hcbd_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/hcbd_back.sv -----
// ----------------------------------------------------------------------------
// hcbd_back
// Decode side: length and chunked parsing, result register.
// ----------------------------------------------------------------------------
module hcbd_back #(
  parameter int unsigned MaxHexDigits = hcbd_pkg::MAX_HEX_DIGITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hcbd_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            q_valid_i,
  input  hcbd_pkg::item_t                 q_item_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            payload_valid_o,
  output logic [7:0]                      payload_byte_o,
  output logic                            body_complete_o,
  output logic                            size_error_o,
  output logic [1:0]                      parse_phase_o,
  output logic [hcbd_pkg::COUNT_W-1:0]    payload_count_o
);

  localparam int unsigned DigitW = $clog2(MaxHexDigits + 1);
  localparam int unsigned CntW   = hcbd_pkg::COUNT_W;

  logic                 chunked_q;
  logic [CntW-1:0]      expected_q;
  hcbd_pkg::phase_e     phase_q, phase_d;
  logic [31:0]          accum_q, accum_d;
  logic [DigitW-1:0]    digits_q, digits_d;
  logic                 ended_q, ended_d;
  logic                 cr_seen_q, cr_seen_d;
  logic [31:0]          remain_q, remain_d;
  logic [1:0]           skip_q, skip_d;
  logic [CntW-1:0]      total_q, total_d;
  logic                 done_q, done_d;
  logic                 error_q, error_d;

  logic                 res_valid;
  logic                 ended;
  logic [CntW-1:0]      total_inc;
  logic [31:0]          remain_dec;
  logic [1:0]           skip_dec;
  logic                 restart;

  logic                 out_pv_q;
  logic [7:0]           out_byte_q;
  logic                 out_done_q, out_err_q, out_valid_q;
  logic [1:0]           out_phase_q;
  logic [CntW-1:0]      out_cnt_q;

  assign q_pop_o   = q_valid_i & (~out_valid_q | out_ready_i);
  assign restart   = cfg_we_i &
                     ((cfg_addr_i == hcbd_pkg::REG_CHUNKED_MODE) ||
                      (cfg_addr_i == hcbd_pkg::REG_EXPECTED_LENGTH));
  assign total_inc = (&total_q) ? total_q : total_q + 1'b1;
  assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : remain_q;
  assign skip_dec   = (skip_q != '0) ? skip_q - 1'b1 : skip_q;

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    digits_d  = digits_q;
    ended_d   = ended_q;
    cr_seen_d = cr_seen_q;
    remain_d  = remain_q;
    skip_d    = skip_q;
    total_d   = total_q;
    done_d    = done_q;
    error_d   = error_q;
    res_valid = 1'b0;
    ended     = ended_q;
    if (!done_q) begin
      if (!chunked_q) begin
        res_valid = 1'b1;
        total_d   = total_inc;
        if (total_inc >= expected_q) begin
          done_d  = 1'b1;
          phase_d = hcbd_pkg::PH_DONE;
        end else begin
          phase_d = hcbd_pkg::PH_DATA;
        end
      end else begin
        case (phase_q)
          hcbd_pkg::PH_SIZE: begin
            if (cr_seen_q) begin
              cr_seen_d = 1'b0;
              ended     = 1'b1;
            end
            if (cr_seen_q && q_item_i.is_lf) begin
              if (accum_q == '0) begin
                done_d  = 1'b1;
                phase_d = hcbd_pkg::PH_DONE;
              end else begin
                remain_d = accum_q;
                phase_d  = hcbd_pkg::PH_DATA;
              end
              accum_d  = '0;
              digits_d = '0;
              ended_d  = 1'b0;
            end else if (q_item_i.is_cr) begin
              cr_seen_d = 1'b1;
              ended_d   = ended;
            end else if (!ended && q_item_i.is_hex) begin
              if (digits_q >= DigitW'(MaxHexDigits)) begin
                error_d = 1'b1;
                done_d  = 1'b1;
                phase_d = hcbd_pkg::PH_DONE;
              end else begin
                accum_d  = {accum_q[27:0], q_item_i.nibble};
                digits_d = digits_q + 1'b1;
              end
            end else begin
              ended_d = 1'b1;
            end
          end
          hcbd_pkg::PH_DATA: begin
            res_valid = 1'b1;
            total_d   = total_inc;
            remain_d  = remain_dec;
            if (remain_dec == '0) begin
              phase_d = hcbd_pkg::PH_TRAIL;
              skip_d  = hcbd_pkg::TRAIL_SKIP_BYTES;
            end
          end
          hcbd_pkg::PH_TRAIL: begin
            skip_d = skip_dec;
            if (skip_dec == '0) begin
              phase_d = hcbd_pkg::PH_SIZE;
            end
          end
          default: begin
            done_d  = 1'b1;
            phase_d = hcbd_pkg::PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_q  <= 1'b0;
      expected_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        hcbd_pkg::REG_CHUNKED_MODE:    chunked_q  <= cfg_wdata_i[0];
        hcbd_pkg::REG_EXPECTED_LENGTH: expected_q <= cfg_wdata_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= hcbd_pkg::PH_SIZE;
      accum_q   <= '0;
      digits_q  <= '0;
      ended_q   <= 1'b0;
      cr_seen_q <= 1'b0;
      remain_q  <= '0;
      skip_q    <= '0;
      total_q   <= '0;
      done_q    <= 1'b0;
      error_q   <= 1'b0;
    end else if (restart) begin
      phase_q   <= hcbd_pkg::PH_SIZE;
      accum_q   <= '0;
      digits_q  <= '0;
      ended_q   <= 1'b0;
      cr_seen_q <= 1'b0;
      remain_q  <= '0;
      skip_q    <= '0;
      total_q   <= '0;
      done_q    <= 1'b0;
      error_q   <= 1'b0;
    end else if (q_pop_o) begin
      phase_q   <= phase_d;
      accum_q   <= accum_d;
      digits_q  <= digits_d;
      ended_q   <= ended_d;
      cr_seen_q <= cr_seen_d;
      remain_q  <= remain_d;
      skip_q    <= skip_d;
      total_q   <= total_d;
      done_q    <= done_d;
      error_q   <= error_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_pv_q    <= res_valid;
      out_byte_q  <= res_valid ? q_item_i.data : 8'd0;
      out_done_q  <= done_d;
      out_err_q   <= error_d;
      out_phase_q <= hcbd_pkg::phase_code(phase_d);
      out_cnt_q   <= total_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = out_pv_q;
  assign payload_byte_o  = out_byte_q;
  assign body_complete_o = out_done_q;
  assign size_error_o    = out_err_q;
  assign parse_phase_o   = out_phase_q;
  assign payload_count_o = out_cnt_q;

endmodule

// ----- rtl/http_chunked_body_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// HTTP request body decoder for fixed-length and chunked transfer bodies.
// ----------------------------------------------------------------------------
// Input channel: one raw body byte per beat (in_valid_i / in_ready_o).
// Output channel: one result per input beat (out_valid_o / out_ready_i),
// carrying the payload byte when it belongs to the body, completion and
// size error flags, the parse phase and the running payload count.
// Configuration: cfg_we_i writes register cfg_addr_i (0 chunked mode,
// 1 expected length) from cfg_wdata_i; any write restarts the decoder.
// A beat is held in the queue and then in the result register. Throughput is
// one byte per cycle unless out_ready_i stalls, set by the back side decode step.
// A two-beat queue sits between the byte tagger and the decoder, and the
// result register lets the decoder run while the queue refills.
// When the receiver stalls, the result holds, the queue fills and then
// in_ready_o drops. Reset clears the queue, all parse state and the
// configuration registers (length mode, expected length zero).
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit #(
  parameter int unsigned MaxHexDigits = hcbd_pkg::MAX_HEX_DIGITS,
  parameter int unsigned QueueDepth   = hcbd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hcbd_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            payload_valid_o,
  output logic [7:0]                      payload_byte_o,
  output logic                            body_complete_o,
  output logic                            size_error_o,
  output logic [1:0]                      parse_phase_o,
  output logic [hcbd_pkg::COUNT_W-1:0]    payload_count_o
);

  logic            push, q_ready, q_valid, q_pop;
  hcbd_pkg::item_t push_item, q_item;

  hcbd_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .item_o      (push_item),
    .q_ready_i   (q_ready)
  );

  hcbd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  hcbd_back #(
    .MaxHexDigits (MaxHexDigits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_valid_o (payload_valid_o),
    .payload_byte_o  (payload_byte_o),
    .body_complete_o (body_complete_o),
    .size_error_o    (size_error_o),
    .parse_phase_o   (parse_phase_o),
    .payload_count_o (payload_count_o)
  );

endmodule

// ----- rtl/hcbd_checker.sv -----
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hcbd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [hcbd_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input logic [hcbd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [7:0]                      data_byte_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            payload_valid_o,
  input logic [7:0]                      payload_byte_o,
  input logic                            body_complete_o,
  input logic                            size_error_o,
  input logic [1:0]                      parse_phase_o,
  input logic [hcbd_pkg::COUNT_W-1:0]    payload_count_o
);

  a_error_ends_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_error_o |-> body_complete_o)
    else $error("size error without completed body");

  a_complete_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && body_complete_o |-> parse_phase_o == hcbd_pkg::PHASE_CODE_DONE)
    else $error("completed body not in finished phase");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_byte_o == 8'd0)
    else $error("non-payload beat carries a byte");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(payload_byte_o) && $stable(payload_count_o))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (.*);
